FILE: src/jncu_pkg.sv
// ----------------------------------------------------------------------------
// jncu_pkg
// Shared command codes and the stage 1 -> stage 2 bundle for the numeric conversion unit.
// ----------------------------------------------------------------------------
package jncu_pkg;

  typedef enum logic [3:0] {
    CMD_D2I = 4'd0,
    CMD_D2L = 4'd1,
    CMD_D2F = 4'd2,
    CMD_I2L = 4'd3,
    CMD_I2F = 4'd4,
    CMD_I2D = 4'd5,
    CMD_L2I = 4'd6,
    CMD_L2F = 4'd7,
    CMD_L2D = 4'd8,
    CMD_F2I = 4'd9,
    CMD_F2L = 4'd10,
    CMD_F2D = 4'd11,
    CMD_I2B = 4'd12,
    CMD_I2C = 4'd13,
    CMD_I2S = 4'd14
  } cmd_t;

  // stage 1 -> stage 2 bundle: normalised operand
  typedef struct packed {
    logic [3:0]  cmd;
    logic        sign;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
    logic [63:0] mant;   // normalised, leading one at bit 63
    logic signed [13:0] exp; // unbiased exponent of bit 63
    logic [63:0] raw;    // direct result for non-arithmetic commands
  } norm_t;

endpackage

FILE: src/jncu_norm.sv
// ----------------------------------------------------------------------------
// jncu_norm
// Unpack the operand and normalise its magnitude to a leading one at bit 63.
// ----------------------------------------------------------------------------
module jncu_norm (
  input  logic [3:0]          command,
  input  logic [63:0]         operand_bits,
  output jncu_pkg::norm_t     norm
);

  logic [63:0] lo;
  logic [63:0] mag;
  logic [5:0]  lz;
  logic signed [13:0] top_exp;
  logic [63:0] raw;
  logic        sgn;
  logic        zero_in;
  logic        inf_in;
  logic        nan_in;

  always_comb begin
    lo = {32'd0, operand_bits[31:0]};
    mag = '0;
    top_exp = '0;
    sgn = 1'b0;
    zero_in = 1'b0;
    inf_in = 1'b0;
    nan_in = 1'b0;
    raw = '0;
    case (command)
      jncu_pkg::CMD_D2I, jncu_pkg::CMD_D2L, jncu_pkg::CMD_D2F: begin
        sgn = operand_bits[63];
        inf_in = (operand_bits[62:52] == 11'h7FF) && (operand_bits[51:0] == '0);
        nan_in = (operand_bits[62:52] == 11'h7FF) && (operand_bits[51:0] != '0);
        zero_in = (operand_bits[62:0] == '0);
        mag = {11'd0, operand_bits[62:52] != 11'd0, operand_bits[51:0]};
        top_exp = (operand_bits[62:52] == 11'd0) ? 14'sd11 - 14'sd1022 - 14'sd63 + 14'sd52
                 : $signed({3'd0, operand_bits[62:52]}) - 14'sd1023 - 14'sd52 + 14'sd52
                   - 14'sd52 + 14'sd52;
        raw = {12'd0, operand_bits[51:0]};
      end
      jncu_pkg::CMD_F2I, jncu_pkg::CMD_F2L, jncu_pkg::CMD_F2D: begin
        sgn = operand_bits[31];
        inf_in = (operand_bits[30:23] == 8'hFF) && (operand_bits[22:0] == '0);
        nan_in = (operand_bits[30:23] == 8'hFF) && (operand_bits[22:0] != '0);
        zero_in = (operand_bits[30:0] == '0);
        mag = {40'd0, operand_bits[30:23] != 8'd0, operand_bits[22:0]};
        top_exp = (operand_bits[30:23] == 8'd0) ? -14'sd126
                 : $signed({6'd0, operand_bits[30:23]}) - 14'sd127;
        raw = {41'd0, operand_bits[22:0]};
      end
      jncu_pkg::CMD_I2F, jncu_pkg::CMD_I2D: begin
        sgn = operand_bits[31];
        mag = sgn ? {32'd0, 32'd0 - operand_bits[31:0]} : lo;
        zero_in = (operand_bits[31:0] == '0);
        top_exp = 14'sd63;
      end
      jncu_pkg::CMD_L2F, jncu_pkg::CMD_L2D: begin
        sgn = operand_bits[63];
        mag = sgn ? 64'd0 - operand_bits : operand_bits;
        zero_in = (operand_bits == '0);
        top_exp = 14'sd63;
      end
      jncu_pkg::CMD_I2L: raw = {{32{operand_bits[31]}}, operand_bits[31:0]};
      jncu_pkg::CMD_L2I: raw = lo;
      jncu_pkg::CMD_I2B: raw = {32'd0, {24{operand_bits[7]}}, operand_bits[7:0]};
      jncu_pkg::CMD_I2C: raw = {48'd0, operand_bits[15:0]};
      jncu_pkg::CMD_I2S: raw = {32'd0, {16{operand_bits[15]}}, operand_bits[15:0]};
      default: raw = '0;
    endcase
  end

  // For floating sources top_exp above holds the exponent of the hidden bit
  // position (bit 52 or 23); adjust to bit 63 after normalising.
  always_comb begin
    lz = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) lz = 6'(63 - i);
    end
  end

  logic signed [13:0] src_top;
  always_comb begin
    case (command)
      jncu_pkg::CMD_D2I, jncu_pkg::CMD_D2L, jncu_pkg::CMD_D2F:
        src_top = ((operand_bits[62:52] == 11'd0) ? -14'sd1022
                  : $signed({3'd0, operand_bits[62:52]}) - 14'sd1023) + 14'sd11;
      jncu_pkg::CMD_F2I, jncu_pkg::CMD_F2L, jncu_pkg::CMD_F2D:
        src_top = top_exp + 14'sd40;
      default: src_top = top_exp;
    endcase
  end

  always_comb begin
    norm.cmd = command;
    norm.sign = sgn;
    norm.is_zero = zero_in;
    norm.is_inf = inf_in;
    norm.is_nan = nan_in;
    norm.mant = mag << lz;
    norm.exp = src_top - $signed({8'd0, lz});
    norm.raw = raw;
  end

endmodule

FILE: src/jvm_numeric_conversion_unit.sv
// ----------------------------------------------------------------------------
// jvm_numeric_conversion_unit
// JVM primitive conversion bytecodes on raw operand bits.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy is never raised.
// Each result appears on result_bits, marked by done for one cycle, once its
// request has passed the registered stages: unpack and normalise, align, round, pack.
// The receiver cannot stall the pipeline, so results must be taken as shown.
// ----------------------------------------------------------------------------
module jvm_numeric_conversion_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [63:0] operand_bits,
  output logic        done,
  output logic [63:0] result_bits
);

  jncu_pkg::norm_t n0, n1;
  logic v1, v2, v3, v4;

  assign busy = 1'b0;

  jncu_norm u_norm (
    .command      (command),
    .operand_bits (operand_bits),
    .norm         (n0)
  );

  // stage 1: normalised operand
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    n1 <= n0;
  end

  // stage 2: align. Shift so that the kept part ends at bit 64 of wide,
  // with the round bit and sticky bits below.
  logic is_fp_dst, dst_dbl, is_int_dst, dst_long;
  logic signed [13:0] emin_top, keep_lsb_e;
  logic [13:0] sh;
  logic [63:0] q;
  logic        rnd, stk;
  logic        ovf;
  logic [63:0] sat;
  logic [127:0] wide;

  always_comb begin
    dst_dbl = (n1.cmd == jncu_pkg::CMD_I2D) || (n1.cmd == jncu_pkg::CMD_L2D)
           || (n1.cmd == jncu_pkg::CMD_F2D);
    is_fp_dst = dst_dbl || (n1.cmd == jncu_pkg::CMD_I2F) || (n1.cmd == jncu_pkg::CMD_L2F)
             || (n1.cmd == jncu_pkg::CMD_D2F);
    dst_long = (n1.cmd == jncu_pkg::CMD_D2L) || (n1.cmd == jncu_pkg::CMD_F2L);
    is_int_dst = dst_long || (n1.cmd == jncu_pkg::CMD_D2I) || (n1.cmd == jncu_pkg::CMD_F2I);
    emin_top = dst_dbl ? -14'sd1022 : -14'sd126;
    if (is_fp_dst) begin
      // exponent of LSB kept
      keep_lsb_e = ((n1.exp < emin_top) ? emin_top : n1.exp)
                 - (dst_dbl ? 14'sd52 : 14'sd23);
    end else begin
      keep_lsb_e = 14'sd0;
    end
    sh = 14'(keep_lsb_e - (n1.exp - 14'sd63));
    if (sh > 14'd127) begin
      wide = '0;
      q = '0; rnd = 1'b0; stk = (n1.mant != '0);
    end else begin
      wide = {n1.mant, 64'd0} >> sh[6:0];
      q = wide[127:64];
      rnd = wide[63];
      stk = (wide[62:0] != '0);
    end
    ovf = dst_long ? (n1.exp >= 14'sd63) : (n1.exp >= 14'sd31);
    sat = dst_long ? (n1.sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                   : (n1.sign ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF);
  end

  logic        s2, z2, i2, nn2, fp2, dbl2, int2, lng2, ovf2, r2, k2;
  logic [63:0] q2, raw2, sat2;
  logic signed [13:0] e2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    s2 <= n1.sign; z2 <= n1.is_zero; i2 <= n1.is_inf; nn2 <= n1.is_nan;
    fp2 <= is_fp_dst; dbl2 <= dst_dbl; int2 <= is_int_dst; lng2 <= dst_long; ovf2 <= ovf;
    q2 <= q; r2 <= rnd; k2 <= stk; raw2 <= n1.raw; sat2 <= sat;
    e2 <= keep_lsb_e + (dst_dbl ? 14'sd52 : 14'sd23);
  end

  // stage 3: round and integer result
  logic [63:0] qr, ires;
  logic        up;
  always_comb begin
    up = r2 && (k2 || q2[0]);
    qr = q2 + {63'd0, up};
    ires = s2 ? 64'd0 - q2 : q2;
    if (!lng2) ires = {32'd0, ires[31:0]};
  end

  logic        s3, z3, i3, nn3, fp3, dbl3, int3, ovf3;
  logic [63:0] qr3, raw3, sat3, ires3;
  logic signed [13:0] e3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s3 <= s2; z3 <= z2; i3 <= i2; nn3 <= nn2; fp3 <= fp2; dbl3 <= dbl2;
    int3 <= int2; ovf3 <= ovf2; qr3 <= qr; raw3 <= raw2; sat3 <= sat2; ires3 <= ires;
    e3 <= e2;
  end

  // stage 4: pack
  logic [63:0] res;
  logic [53:0] m;
  logic signed [13:0] ef;
  logic [10:0] be;
  always_comb begin
    res = '0;
    m = dbl3 ? qr3[53:0] : {29'd0, qr3[24:0]};
    // carry out of rounding moves up one binade
    ef = e3;
    if (dbl3 ? m[53] : m[24]) begin
      ef = e3 + 14'sd1;
      m = m >> 1;
    end
    be = '0;
    if (fp3) begin
      if (dbl3) begin
        if (nn3) res = {s3, 11'h7FF, 1'b1, raw3[21:0], 29'd0};
        else if (z3) res = {s3, 63'd0};
        else if (i3 || ef > 14'sd1023) res = {s3, 11'h7FF, 52'd0};
        else begin
          be = m[52] ? 11'(ef + 14'sd1023) : 11'd0;
          res = {s3, be, m[51:0]};
        end
      end else begin
        if (nn3) res = {32'd0, s3, 8'hFF, 1'b1, raw3[50:29]};
        else if (z3) res = {32'd0, s3, 31'd0};
        else if (i3 || ef > 14'sd127) res = {32'd0, s3, 8'hFF, 23'd0};
        else begin
          be = m[23] ? {3'd0, 8'(ef + 14'sd127)} : 11'd0;
          res = {32'd0, s3, be[7:0], m[22:0]};
        end
      end
    end else if (int3) begin
      if (nn3 || z3) res = '0;
      else if (i3 || ovf3) res = sat3;
      else res = ires3;
    end else begin
      res = raw3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    result_bits <= res;
  end

  assign done = v4;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start ##4 1'b1 |-> done) else $error("result lost");
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    v2 |=> v3) else $error("valid dropped");
`endif

endmodule
